@@ design/scale_note_pitch_correction_ratio_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pitch correction block
// Shared wrappers for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SCALE_NOTE_PITCH_CORRECTION_RATIO_ASSERT_SVH
`define SCALE_NOTE_PITCH_CORRECTION_RATIO_ASSERT_SVH

// Same-cycle implication.
`define SNPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SNPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/snpc_pkg.sv @@
// ----------------------------------------------------------------------------
// snpc_pkg
// Types, constants and constant tables of the nearest scale note corrector.
// ----------------------------------------------------------------------------
package snpc_pkg;

  localparam int OCTAVES_DEF        = 8;
  localparam int FREQ_FRAC_BITS_DEF = 6;

  localparam int FREQ_W      = 16;
  localparam int FACTOR_W    = 24;
  localparam int NOTE_W      = 20;
  localparam int INDEX_W     = 6;
  localparam int INTENSITY_W = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MINOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 2'd2;

  localparam logic [3:0]             ROOT_MAX       = 4'd11;
  localparam logic [INTENSITY_W-1:0] INTENSITY_RST  = 16'd32768;
  localparam int                     ROOT_COUNT     = 12;
  localparam int                     STEPS_PER_OCT  = 8;

  // log2 / exp2 fixed point.
  localparam int LOG_FRAC = 24;
  localparam int LOG_X_W  = 32;
  localparam int MANT_W   = 31;
  localparam int EXP_W    = 5;
  localparam int LOG_W    = EXP_W + LOG_FRAC;
  localparam int STEP_W   = 5;
  localparam int EM_W     = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;

  localparam logic [15:0] ROOT_HUNDREDTHS [ROOT_COUNT] = '{
    16'd26163, 16'd27718, 16'd29366, 16'd31113, 16'd32963, 16'd34923,
    16'd36999, 16'd39200, 16'd41530, 16'd44000, 16'd46616, 16'd49388
  };

  localparam logic [17:0] SEMITONE_Q16 [13] = '{
    18'd65536, 18'd69433, 18'd73562, 18'd77936, 18'd82570, 18'd87480, 18'd92682,
    18'd98193, 18'd104032, 18'd110218, 18'd116772, 18'd123715, 18'd131072
  };

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_SEARCH   = 4'd2;
  localparam logic [OP_W-1:0] OP_DRAIN    = 4'd3;
  localparam logic [OP_W-1:0] OP_BYPASS   = 4'd4;
  localparam logic [OP_W-1:0] OP_LOG_LOAD = 4'd5;
  localparam logic [OP_W-1:0] OP_LOG_NORM = 4'd6;
  localparam logic [OP_W-1:0] OP_LOG_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_LOG_SQ   = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL      = 4'd9;
  localparam logic [OP_W-1:0] OP_EXP_INIT = 4'd10;
  localparam logic [OP_W-1:0] OP_EXP_STEP = 4'd11;
  localparam logic [OP_W-1:0] OP_FINISH   = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              sel;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic freq_zero;
    logic search_last;
    logic norm_done;
  } dp_status_t;

  typedef logic [EM_W-1:0] exp_tab_t [LOG_FRAC];

  // Semitone offset of a step inside the octave (step 0 is the root).
  function automatic int semis_of(input int minor, input int step);
    int r;
    r = 12;
    if (step == 0) begin
      r = 0;
    end else if (minor != 0) begin
      case (step)
        1: r = 2;
        2: r = 3;
        3: r = 5;
        4: r = 7;
        5: r = 8;
        6: r = 10;
        default: r = 12;
      endcase
    end else begin
      case (step)
        1: r = 2;
        2: r = 4;
        3: r = 5;
        4: r = 7;
        5: r = 9;
        6: r = 11;
        default: r = 12;
      endcase
    end
    return r;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bits;
    v    = v_in;
    res  = 0;
    bits = 64'h4000_0000_0000_0000;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v   = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Q30 factors 2^(2^-k), k = 1 .. LOG_FRAC, by repeated square roots of 2.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        t;
    longint unsigned c;
    int              k;
    c = 64'd2 << 30;
    for (k = 0; k < LOG_FRAC; k++) begin
      c    = isqrt64(c << 30);
      t[k] = EM_W'(c);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_ROOT = build_exp_tab();

endpackage

@@ design/snpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// snpc_ctrl
// Sequencer: zero-frequency bypass, or note scan, two log2 passes, exponent product, exp2 steps.
// ----------------------------------------------------------------------------
module snpc_ctrl
  import snpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SEARCH = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_LLOAD  = 4'd4;
  localparam logic [3:0] S_LNORM  = 4'd5;
  localparam logic [3:0] S_LINIT  = 4'd6;
  localparam logic [3:0] S_LSQ    = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_EINIT  = 4'd9;
  localparam logic [3:0] S_ESTEP  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LOG_FRAC - 1);

  logic [3:0]        state, state_next;
  logic              sel, sel_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      step  <= step_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    sel_next   = sel;
    step_next  = step;
    cmd.op     = OP_IDLE;
    cmd.sel    = sel;
    cmd.step   = step;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.freq_zero) begin
          cmd.op     = OP_BYPASS;
          state_next = S_IDLE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.op = OP_SEARCH;
        if (status.search_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.op     = OP_DRAIN;
        sel_next   = 1'b0;
        state_next = S_LLOAD;
      end
      S_LLOAD: begin
        cmd.op     = OP_LOG_LOAD;
        state_next = S_LNORM;
      end
      S_LNORM: begin
        cmd.op = OP_LOG_NORM;
        if (status.norm_done) state_next = S_LINIT;
      end
      S_LINIT: begin
        cmd.op     = OP_LOG_INIT;
        step_next  = '0;
        state_next = S_LSQ;
      end
      S_LSQ: begin
        cmd.op = OP_LOG_SQ;
        if (step == STEP_LAST) begin
          if (!sel) begin
            sel_next   = 1'b1;
            state_next = S_LLOAD;
          end else begin
            state_next = S_MUL;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_EINIT;
      end
      S_EINIT: begin
        cmd.op     = OP_EXP_INIT;
        step_next  = '0;
        state_next = S_ESTEP;
      end
      S_ESTEP: begin
        cmd.op = OP_EXP_STEP;
        if (step == STEP_LAST) begin
          state_next = S_FIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_FIN: begin
        cmd.op     = OP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/snpc_datapath.sv @@
// ----------------------------------------------------------------------------
// snpc_datapath
// Note ROM scan, shared log2 squaring unit, exponent product and exp2 unit.
// ----------------------------------------------------------------------------
module snpc_datapath
  import snpc_pkg::*;
#(
  parameter int OCTAVES        = OCTAVES_DEF,
  parameter int FREQ_FRAC_BITS = FREQ_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [FREQ_W-1:0]      freq_hz,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic                   done,
  output logic [FACTOR_W-1:0]    shift_factor,
  output logic [NOTE_W-1:0]      target_note_hz,
  output logic [INDEX_W-1:0]     note_index,
  output logic                   bypass
);

  localparam int OCT_W     = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
  localparam int IDX_W     = OCT_W + 3;
  localparam int FQ_W      = FREQ_W + FREQ_FRAC_BITS;
  localparam int CMP_W     = (FQ_W > NOTE_W) ? FQ_W : NOTE_W;
  localparam int ROM_DEPTH = ROOT_COUNT * 2 * STEPS_PER_OCT * OCTAVES;
  localparam int ADDR_W    = $clog2(ROM_DEPTH);
  localparam int NOTE_SH   = 20 - FREQ_FRAC_BITS;

  typedef logic [NOTE_W-1:0] note_rom_t [ROM_DEPTH];

  // Unsigned quotient by restoring long division, used only to build the ROM.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, rem;
    int              i;
    q   = 0;
    rem = 0;
    for (i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Entry order: root, scale, step, octave (octave varies fastest).
  function automatic note_rom_t build_rom();
    note_rom_t       t;
    longint unsigned prod, den, v;
    int              r, mi, s, o, sh, idx;
    for (r = 0; r < ROOT_COUNT; r++) begin
      for (mi = 0; mi < 2; mi++) begin
        for (s = 0; s < STEPS_PER_OCT; s++) begin
          for (o = 0; o < OCTAVES; o++) begin
            prod = longint'(ROOT_HUNDREDTHS[r]) * longint'(SEMITONE_Q16[semis_of(mi, s)]);
            sh   = NOTE_SH - o;
            if (sh >= 0) begin
              den = 64'd100 << sh;
            end else begin
              prod = prod << (-sh);
              den  = 64'd100;
            end
            v = udiv64(prod + (den >> 1), den);
            if (v > 64'hFFFFF) v = 64'hFFFFF;
            idx    = ((r * 2 + mi) * STEPS_PER_OCT + s) * OCTAVES + o;
            t[idx] = NOTE_W'(v);
          end
        end
      end
    end
    return t;
  endfunction

  localparam note_rom_t NOTE_ROM = build_rom();

  // Configuration registers.
  logic [3:0]             root_note;
  logic                   scale_minor;
  logic [INTENSITY_W-1:0] intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_note   <= '0;
      scale_minor <= 1'b0;
      intensity   <= INTENSITY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROOT_NOTE:   root_note   <= cfg_data[3:0];
        REG_SCALE_MINOR: scale_minor <= cfg_data[0];
        REG_INTENSITY:   intensity   <= cfg_data[INTENSITY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture and note scan.
  logic [FREQ_W-1:0] freq;
  logic [FQ_W-1:0]   fq;
  logic [OCT_W-1:0]  oct_cnt;
  logic [2:0]        stp_cnt;
  logic [3:0]        root_c;
  logic [7:0]        rs_step;
  logic [ADDR_W-1:0] rom_addr;
  logic [NOTE_W-1:0] rom_q;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [NOTE_W-1:0] best_note;
  logic [CMP_W-1:0]  best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic [CMP_W-1:0]  cand, fq_ext, note_dist;

  assign fq        = {freq, {FREQ_FRAC_BITS{1'b0}}};
  assign root_c    = (root_note > ROOT_MAX) ? ROOT_MAX : root_note;
  assign rs_step   = {root_c, scale_minor, stp_cnt};
  assign rom_addr  = ADDR_W'(32'(rs_step) * 32'(OCTAVES) + 32'(oct_cnt));
  assign cand      = CMP_W'(rom_q);
  assign fq_ext    = CMP_W'(fq);
  assign note_dist = (cand > fq_ext) ? (cand - fq_ext) : (fq_ext - cand);

  assign status.freq_zero   = (freq == '0);
  assign status.search_last = (oct_cnt == OCT_W'(OCTAVES - 1)) && (stp_cnt == 3'd7);

  always_ff @(posedge clk) begin
    rom_q <= NOTE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      oct_cnt  <= '0;
      stp_cnt  <= '0;
    end else begin
      rd_valid <= (cmd.op == OP_SEARCH);
      if (cmd.op == OP_LOAD) begin
        oct_cnt <= '0;
        stp_cnt <= '0;
      end else if (cmd.op == OP_SEARCH) begin
        stp_cnt <= stp_cnt + 1'b1;
        if (stp_cnt == 3'd7) oct_cnt <= oct_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= {oct_cnt, stp_cnt};
    if (cmd.op == OP_LOAD) freq <= freq_hz;
    // The first note always wins; later ones only when strictly nearer.
    if (rd_valid && ((rd_idx == '0) || (note_dist < best_dist))) begin
      best_note <= rom_q;
      best_dist <= note_dist;
      best_idx  <= rd_idx;
    end
  end

  // Shared log2 unit: normalize, then 24 squaring steps of the Q30 mantissa.
  logic [LOG_X_W-1:0]  norm;
  logic [EXP_W-1:0]    le;
  logic [MANT_W-1:0]   lm;
  logic [LOG_W-1:0]    lacc;
  logic [LOG_W-1:0]    lnote;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sqt;

  assign sq               = lm * lm;
  assign sqt              = sq[2*MANT_W-1:MANT_W-1];
  assign status.norm_done = norm[LOG_X_W-1];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOG_LOAD: begin
        norm <= cmd.sel ? LOG_X_W'(fq) : LOG_X_W'(best_note);
        le   <= EXP_W'(LOG_X_W - 1);
        if (cmd.sel) lnote <= lacc;
      end
      OP_LOG_NORM: begin
        if (!norm[LOG_X_W-1]) begin
          norm <= norm << 1;
          le   <= le - 1'b1;
        end
      end
      OP_LOG_INIT: begin
        lm   <= norm[LOG_X_W-1:1];
        lacc <= {le, {LOG_FRAC{1'b0}}};
      end
      OP_LOG_SQ: begin
        if (sqt[MANT_W]) begin
          lm   <= sqt[MANT_W:1];
          lacc <= lacc | (LOG_W'(1) << (STEP_W'(LOG_FRAC - 1) - cmd.step));
        end else begin
          lm <= sqt[MANT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Exponent y = floor((log2 note - log2 freq) * intensity / 2^15), Q.24.
  logic signed [LOG_W:0]               lr;
  logic signed [LOG_W+INTENSITY_W+1:0] prod;
  logic signed [31:0]                  y;

  assign lr   = $signed({1'b0, lnote}) - $signed({1'b0, lacc});
  assign prod = lr * $signed({1'b0, intensity});

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL) y <= 32'(prod >>> 15);
  end

  // exp2: product of the Q30 factors selected by the fraction bits.
  logic signed [7:0]   ip;
  logic [LOG_FRAC-1:0] frac;
  logic [EM_W-1:0]     em;
  logic [2*EM_W-1:0]   em_prod;
  logic [STEP_W-1:0]   frac_bit;

  assign em_prod  = 64'(em) * 64'(EXP_ROOT[cmd.step]) + 64'(32'h2000_0000);
  assign frac_bit = STEP_W'(LOG_FRAC - 1) - cmd.step;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_EXP_INIT: begin
        ip   <= y[31:24];
        frac <= y[LOG_FRAC-1:0];
        em   <= 32'h4000_0000;
      end
      OP_EXP_STEP: begin
        if (frac[frac_bit]) em <= em_prod[EM_W+29:30];
      end
      default: ;
    endcase
  end

  // Final scaling of 2^ip * m to Q5.19 with rounding and saturation.
  logic [5:0]          sh;
  logic [39:0]         rnd;
  logic [FACTOR_W-1:0] factor;

  assign sh  = 6'(8'sd11 - ip);
  assign rnd = (40'(em) + (40'd1 << (sh - 1'b1))) >> sh;

  always_comb begin
    if (ip >= 8'sd5) begin
      factor = FACTOR_MAX;
    end else if (ip <= -8'sd29) begin
      factor = '0;
    end else if (rnd > 40'(FACTOR_MAX)) begin
      factor = FACTOR_MAX;
    end else begin
      factor = rnd[FACTOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_FINISH) || (cmd.op == OP_BYPASS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      shift_factor   <= factor;
      target_note_hz <= best_note;
      note_index     <= INDEX_W'(best_idx);
      bypass         <= 1'b0;
    end else if (cmd.op == OP_BYPASS) begin
      shift_factor   <= '0;
      target_note_hz <= '0;
      note_index     <= '0;
      bypass         <= 1'b1;
    end
  end

endmodule

@@ design/scale_note_pitch_correction_ratio.sv @@
// Sequence: a zero frequency is checked and transferred as a bypass result; otherwise the
// scan reads one ROM entry a cycle, then two log2 passes (load, normalize, 24 squarings)
// run on the note and on freq_hz*2^FREQ_FRAC_BITS, and exp2 takes 24 steps.
// Throughput: one item at a time; busy falls with the result strobe, so the next start can
// be taken at the edge that transfers the result. The receiver cannot stall.
// Reset: root_note = 0, scale_minor = 0, intensity = 32768, controller idle.
// ----------------------------------------------------------------------------
// scale_note_pitch_correction_ratio
// Picks the nearest major/minor scale note and returns (note/freq)^intensity.
// ----------------------------------------------------------------------------
module scale_note_pitch_correction_ratio
  import snpc_pkg::*;
#(
  parameter int OCTAVES        = OCTAVES_DEF,
  parameter int FREQ_FRAC_BITS = FREQ_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FREQ_W-1:0]    freq_hz,
  output logic                 done,
  output logic [FACTOR_W-1:0]  shift_factor,
  output logic [NOTE_W-1:0]    target_note_hz,
  output logic [INDEX_W-1:0]   note_index,
  output logic                 bypass,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  snpc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  snpc_datapath #(
    .OCTAVES        (OCTAVES),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .freq_hz        (freq_hz),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .done           (done),
    .shift_factor   (shift_factor),
    .target_note_hz (target_note_hz),
    .note_index     (note_index),
    .bypass         (bypass)
  );

endmodule

@@ design/snpc_checker.sv @@
// ----------------------------------------------------------------------------
// snpc_checker
// Port-level checks of the pitch correction block, bound to the top level.
// ----------------------------------------------------------------------------
`include "scale_note_pitch_correction_ratio_assert.svh"

module snpc_checker
  import snpc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [FREQ_W-1:0]   freq_hz,
  input logic                done,
  input logic [FACTOR_W-1:0] shift_factor,
  input logic                bypass
);

  // A zero frequency is answered with a bypass result.
  `SNPC_ASSERT_IMP(a_zero_bypass, clk, rst, start && !busy && (freq_hz == '0), ##2 (done && bypass), "zero frequency did not bypass")

  // A bypassed result carries no correction.
  `SNPC_ASSERT_IMP(a_bypass_factor, clk, rst, done && bypass, shift_factor == '0, "bypass with nonzero factor")

  // The result strobe marks a single cycle.
  `SNPC_ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")

  // The block is free again when its result transfers.
  `SNPC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "busy during result transfer")

endmodule

bind scale_note_pitch_correction_ratio snpc_checker u_snpc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .freq_hz      (freq_hz),
  .done         (done),
  .shift_factor (shift_factor),
  .bypass       (bypass)
);

@@ tb/tb_scale_note_pitch_correction_ratio.sv @@
// ----------------------------------------------------------------------------
// Testbench for scale_note_pitch_correction_ratio
// Drives detected frequencies under several scale settings and intensities,
// predicts the nearest note and the correction factor, and checks each result.
// ----------------------------------------------------------------------------
module tb_scale_note_pitch_correction_ratio
  import snpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 230;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [NOTE_W-1:0]   note;
    logic [INDEX_W-1:0]  idx;
    logic                byp;
  } correction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [FREQ_W-1:0] freq_hz = '0;
  logic done;
  logic [FACTOR_W-1:0] shift_factor;
  logic [NOTE_W-1:0] target_note_hz;
  logic [INDEX_W-1:0] note_index;
  logic bypass;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  scale_note_pitch_correction_ratio dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [3:0] root_sel = 4'd0;
  logic minor_sel = 1'b0;
  logic [15:0] strength = 16'd32768;
  longint unsigned half_step_q30 [LOG_FRAC];

  correction_t pending_q[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int bypassed = 0;
  int sender_idle_pct = 0;
  longint cycles = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int semitones(input logic minor, input int step);
    int maj [8] = '{0, 2, 4, 5, 7, 9, 11, 12};
    int mnr [8] = '{0, 2, 3, 5, 7, 8, 10, 12};
    return minor ? mnr[step] : maj[step];
  endfunction

  function automatic longint unsigned scale_note(input longint unsigned root_h, input int semis,
                                                 input int octave);
    longint unsigned prod, den, v;
    int sh;
    prod = root_h * SEMITONE_Q16[semis];
    sh = 20 - FREQ_FRAC_BITS_DEF - octave;
    if (sh >= 0) begin
      den = 64'd100 << sh;
    end else begin
      prod = prod << (-sh);
      den = 100;
    end
    v = (prod + den / 2) / den;
    return (v > 64'hFFFFF) ? 64'hFFFFF : v;
  endfunction

  // log2 in Q.24 by msb position and repeated squaring of a Q30 mantissa.
  function automatic longint log2_q24(input longint unsigned x);
    int e;
    longint unsigned m;
    longint r;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    r = longint'(e) <<< LOG_FRAC;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r + (longint'(1) <<< (LOG_FRAC - i));
      end
    end
    return r;
  endfunction

  function automatic longint unsigned pow2_q19(input longint y);
    longint ip;
    longint unsigned frac, m;
    int sh;
    if (y >= 0) ip = y >>> LOG_FRAC;
    else ip = -(((-y) + ((longint'(1) <<< LOG_FRAC) - 1)) >>> LOG_FRAC);
    frac = longint'(y - ip * (longint'(1) <<< LOG_FRAC));
    if (ip >= 5) return 64'hFFFFFF;
    m = 64'd1 << 30;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      if ((frac >> (LOG_FRAC - k)) & 1) m = (m * half_step_q30[k-1] + (64'd1 << 29)) >> 30;
    end
    sh = 11 - int'(ip);
    if (sh >= 40) return 0;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (m > 64'hFFFFFF) ? 64'hFFFFFF : m;
  endfunction

  function automatic correction_t predict_correction(input logic [15:0] f);
    correction_t c;
    longint unsigned fq, n, d, best_note, best_dist, root_h;
    int best_idx;
    longint lr, prod, y;
    c = '0;
    if (f == 0) begin
      c.byp = 1'b1;
      return c;
    end
    root_h = ROOT_HUNDREDTHS[(root_sel > ROOT_MAX) ? ROOT_MAX : root_sel];
    fq = longint'(f) << FREQ_FRAC_BITS_DEF;
    best_note = 0;
    best_dist = 0;
    best_idx = 0;
    for (int o = 0; o < OCTAVES_DEF; o++) begin
      for (int s = 0; s < STEPS_PER_OCT; s++) begin
        n = scale_note(root_h, semitones(minor_sel, s), o);
        d = (n > fq) ? n - fq : fq - n;
        if ((o == 0 && s == 0) || d < best_dist) begin
          best_dist = d;
          best_note = n;
          best_idx = o * 8 + s;
        end
      end
    end
    lr = log2_q24(best_note) - log2_q24(fq);
    prod = lr * longint'(strength);
    if (prod >= 0) y = prod >>> 15;
    else y = -(((-prod) + 32767) >>> 15);
    c.factor = FACTOR_W'(pow2_q19(y));
    c.note = NOTE_W'(best_note);
    c.idx = INDEX_W'(best_idx);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
  endtask

  always @(posedge clk) begin
    if (!rst) cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Result checker: the block cannot be stalled, so every strobe is a transfer.
  always @(posedge clk) begin
    correction_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_q.pop_front();
        if (shift_factor !== want.factor) report_mismatch("shift_factor", shift_factor, want.factor);
        if (target_note_hz !== want.note) report_mismatch("target_note_hz", target_note_hz, want.note);
        if (note_index !== want.idx) report_mismatch("note_index", note_index, want.idx);
        if (bypass !== want.byp) report_mismatch("bypass", bypass, want.byp);
      end
      checked++;
    end
  end

  task automatic send_freq(input logic [15:0] f);
    @(posedge clk);
    start <= 1'b1;
    freq_hz <= f;
    do @(posedge clk); while (busy);
    pending_q = {pending_q, predict_correction(f)};
    sent++;
    if (f == 0) bypassed++;
    start <= 1'b0;
    freq_hz <= 16'($urandom);
    if ($urandom_range(99) < sender_idle_pct) repeat ($urandom_range(1, 200)) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ROOT_NOTE: root_sel = val[3:0];
      REG_SCALE_MINOR: minor_sel = val[0];
      REG_INTENSITY: strength = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] random_freq();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(20, 5000));
      2: return 16'($urandom_range(1, 40));
      default: return 16'($urandom_range(5000, 40000));
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] picks [] = '{16'd0, 16'd1, 16'd65535, 16'd262, 16'd440, 16'd466,
                              16'd16, 16'd33000, 16'd20000, 16'd2, 16'd100, 16'd1000};
    foreach (picks[i]) send_freq(picks[i]);
    write_reg(REG_ROOT_NOTE, 16'd15);  // out of range acts as B
    write_reg(REG_SCALE_MINOR, 16'hFFFF);
    write_reg(REG_INTENSITY, 16'd65535);
    send_freq(16'd494);
    send_freq(16'd3);
    send_freq(16'd60000);
    write_reg(REG_INTENSITY, 16'd0);
    send_freq(16'd300);
    send_freq(16'd0);
    write_reg(REG_SPARE, 16'hFFFF);  // must be ignored
    write_reg(REG_INTENSITY, 16'd49152);
    send_freq(16'd1);  // pushes the factor towards saturation
    send_freq(16'd65535);
    send_freq(16'd255);
  endtask

  task automatic test_random(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        write_reg(REG_ROOT_NOTE, 16'($urandom_range(15)));
        write_reg(REG_SCALE_MINOR, 16'($urandom));
        write_reg(REG_INTENSITY, ($urandom_range(3) == 0) ? 16'($urandom_range(1) * 65535)
                                                          : 16'($urandom));
      end
      if (i % 97 == 50) drain();  // sender waits for every outstanding result
      send_freq(($urandom_range(30) == 0) ? 16'd0 : random_freq());
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    for (int k = 0; k < LOG_FRAC; k++)
      half_step_q30[k] = int_sqrt(((k == 0) ? (64'd2 << 30) : half_step_q30[k-1]) << 30);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(360, 0);
    test_random(360, 81);
    test_random(360, 15);
    drain();
    $display("covered %0d frequencies (%0d bypassed), %0d results checked", sent, bypassed,
             checked);
    $display("roots incl. out of range, major and minor, intensity from 0 to full scale");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
